/* hw/rtl/mae_pkg.sv */
// Shared constants, types and command/status bundles for the mail address extractor.
// Used by mae_ctrl, mae_dpath and the top level; no dependencies.
package mae_pkg;

    localparam int ADDR_BYTES = 256;
    localparam int MAX_NEST   = 15;

    localparam int AW     = $clog2(ADDR_BYTES);
    localparam int LW     = $clog2(ADDR_BYTES + 1);
    localparam int TW     = $clog2(ADDR_BYTES + 3);
    localparam int NEST_W = $clog2(MAX_NEST + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [1:0] RSN_END  = 2'd0;
    localparam logic [1:0] RSN_SEP  = 2'd1;
    localparam logic [1:0] RSN_WORD = 2'd2;
    localparam logic [1:0] RSN_NAME = 2'd3;

    typedef struct packed {
        logic       clear;      // new scan: drop length, count, flag
        logic       put;        // append current byte
        logic       clr_len;    // restart collection
        logic       take;       // count byte as consumed
        logic       set_ovf;
        logic       emit;       // start packing the address
        logic       wrap;
        logic [1:0] reason;
        logic       fetch;      // gather bytes of the current word
        logic       next_word;
    } t_cmd;

    typedef struct packed {
        logic len_nz;
        logic word_done;
        logic last;
    } t_stat;

endpackage

/* hw/rtl/mae_if.sv */
// Valid/ready channel interfaces: header byte input and packed address word output.
// Depends on nothing.
interface mae_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       first;

    modport source (output valid, ch, first, input ready);
    modport sink   (input valid, ch, first, output ready);
endinterface

interface mae_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;
    logic [3:0]  byte_count;
    logic        last;
    logic [1:0]  stop_reason;
    logic [15:0] consumed;
    logic        overflow;

    modport source (output valid, data, byte_count, last, stop_reason, consumed, overflow,
                    input ready);
    modport sink   (input valid, data, byte_count, last, stop_reason, consumed, overflow,
                    output ready);
endinterface

/* hw/rtl/mae_dpath.sv */
// Datapath: address byte memory, length/consumed/overflow counters and word packer.
// Depends on mae_pkg; driven by commands from mae_ctrl.
module mae_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_ch,
    input  mae_pkg::t_cmd  i_cmd,
    output mae_pkg::t_stat o_stat,
    output logic [63:0]    o_data,
    output logic [3:0]     o_byte_count,
    output logic [1:0]     o_stop_reason,
    output logic [15:0]    o_consumed,
    output logic           o_overflow
);

    localparam logic [1:0] SRC_MEM = 2'd0;
    localparam logic [1:0] SRC_LT  = 2'd1;
    localparam logic [1:0] SRC_GT  = 2'd2;

    logic [7:0] mem [mae_pkg::ADDR_BYTES];

    logic [mae_pkg::LW-1:0] r_len, n_len, base_len;
    logic [15:0]            r_cons, n_cons;
    logic                   r_ovf, n_ovf;
    logic                   wr_en;

    logic [mae_pkg::TW-1:0] r_pos, r_total, rd_idx;
    logic [3:0]             r_k, r_cnt;
    logic [63:0]            r_word;
    logic                   r_wrap, r_pend;
    logic [1:0]             r_reason, r_src, src;
    logic [7:0]             r_rd, app_byte;
    logic                   issue;

    always_comb begin
        base_len = i_cmd.clear ? '0 : r_len;
        n_len    = base_len;
        n_cons   = i_cmd.clear ? '0 : r_cons;
        n_ovf    = i_cmd.clear ? 1'b0 : r_ovf;
        wr_en    = 1'b0;
        if (i_cmd.clr_len) begin
            n_len = '0;
        end
        if (i_cmd.put) begin
            if (base_len < mae_pkg::LW'(mae_pkg::ADDR_BYTES)) begin
                wr_en = 1'b1;
                n_len = base_len + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.set_ovf) begin
            n_ovf = 1'b1;
        end
        if (i_cmd.take && n_cons != 16'hFFFF) begin
            n_cons = n_cons + 16'd1;
        end
    end

    assign issue  = i_cmd.fetch && (r_pos < r_total) && (r_k < 4'd8);
    assign rd_idx = r_wrap ? r_pos - 1'b1 : r_pos;

    always_comb begin
        src = SRC_MEM;
        if (r_wrap && r_pos == '0) begin
            src = SRC_LT;
        end else if (r_wrap && r_pos == r_total - 1'b1) begin
            src = SRC_GT;
        end
    end

    always_comb begin
        case (r_src)
            SRC_LT:  app_byte = mae_pkg::CH_LT;
            SRC_GT:  app_byte = mae_pkg::CH_GT;
            default: app_byte = r_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[base_len[mae_pkg::AW-1:0]] <= i_ch;
        end
        if (issue) begin
            r_rd <= mem[rd_idx[mae_pkg::AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_cons <= '0;
            r_ovf  <= 1'b0;
            r_pend <= 1'b0;
            r_pos  <= '0;
            r_total <= '0;
            r_k    <= '0;
            r_cnt  <= '0;
        end else begin
            r_len  <= n_len;
            r_cons <= n_cons;
            r_ovf  <= n_ovf;
            r_pend <= issue;
            if (i_cmd.emit) begin
                r_total <= mae_pkg::TW'(n_len) + (i_cmd.wrap ? mae_pkg::TW'(2) : '0);
                r_pos   <= '0;
                r_k     <= '0;
                r_cnt   <= '0;
            end else if (i_cmd.next_word) begin
                r_k   <= '0;
                r_cnt <= '0;
            end else begin
                if (issue) begin
                    r_pos <= r_pos + 1'b1;
                    r_k   <= r_k + 4'd1;
                end
                if (r_pend) begin
                    r_cnt <= r_cnt + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_wrap   <= i_cmd.wrap;
            r_reason <= i_cmd.reason;
        end
        if (issue) begin
            r_src <= src;
        end
        if (i_cmd.emit || i_cmd.next_word) begin
            r_word <= '0;
        end else if (r_pend) begin
            r_word[{r_cnt[2:0], 3'b000} +: 8] <= app_byte;
        end
    end

    assign o_stat.len_nz    = (r_len != '0);
    assign o_stat.word_done = ((r_pos >= r_total) || (r_k == 4'd8)) && !r_pend;
    assign o_stat.last      = (r_pos >= r_total);

    assign o_data        = r_word;
    assign o_byte_count  = r_cnt;
    assign o_stop_reason = r_reason;
    assign o_consumed    = r_cons;
    assign o_overflow    = r_ovf;

endmodule

/* hw/rtl/mae_ctrl.sv */
// Controller: byte scanner state (mode, angle, spacing, comment depth) and emit sequencing.
// Depends on mae_pkg; issues commands to mae_dpath.
module mae_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [7:0]     i_ch,
    input  logic           i_first,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  mae_pkg::t_stat i_stat,
    output mae_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_SCAN  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_SEND  = 2'd2;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_NORMAL  = 3'd1;
    localparam logic [2:0] M_ESCAPE  = 3'd2;
    localparam logic [2:0] M_LITERAL = 3'd3;
    localparam logic [2:0] M_LIT_ESC = 3'd4;
    localparam logic [2:0] M_COMMENT = 3'd5;
    localparam logic [2:0] M_COM_ESC = 3'd6;

    logic [1:0]                r_state, n_state;
    logic [2:0]                r_mode, n_mode, e_mode;
    logic [1:0]                r_angle, n_angle, e_angle;
    logic [1:0]                r_space, n_space, e_space;
    logic                      r_lbr, n_lbr, e_lbr;
    logic [mae_pkg::NEST_W-1:0] r_depth, n_depth, e_depth, dec_depth;
    logic                      len_nz, do_emit, new_word;
    logic [1:0]                rsn;
    logic                      wrp;

    assign o_in_ready  = (r_state == ST_SCAN);
    assign o_out_valid = (r_state == ST_SEND);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        e_mode  = i_first ? M_NORMAL : r_mode;
        e_angle = i_first ? 2'd0 : r_angle;
        e_space = i_first ? 2'd0 : r_space;
        e_lbr   = i_first ? 1'b0 : r_lbr;
        e_depth = i_first ? '0 : r_depth;
        len_nz  = !i_first && i_stat.len_nz;
        new_word = (e_angle == 2'd0) && (e_space == 2'd3) && len_nz;
        dec_depth = (e_depth != '0) ? e_depth - 1'b1 : e_depth;
        n_mode  = r_mode;
        n_angle = r_angle;
        n_space = r_space;
        n_lbr   = r_lbr;
        n_depth = r_depth;
        do_emit = 1'b0;
        rsn     = mae_pkg::RSN_END;
        wrp     = 1'b0;

        case (r_state)
            ST_SCAN: begin
                if (i_in_valid) begin
                    o_cmd.clear = i_first;
                    n_mode  = e_mode;
                    n_angle = e_angle;
                    n_space = e_space;
                    n_lbr   = e_lbr;
                    n_depth = e_depth;
                    if (i_first && i_ch == mae_pkg::CH_LT) begin
                        n_angle    = 2'd1;
                        o_cmd.take = 1'b1;
                    end else if (e_mode == M_IDLE) begin
                        n_mode = M_IDLE;
                    end else if (i_ch == mae_pkg::CH_NUL) begin
                        do_emit = 1'b1;
                        wrp     = (e_angle == 2'd2);
                    end else begin
                        case (e_mode)
                            M_COMMENT: begin
                                o_cmd.take = 1'b1;
                                if (i_ch == mae_pkg::CH_RPAR) begin
                                    n_depth = dec_depth;
                                    if (dec_depth == '0) begin
                                        n_mode  = M_NORMAL;
                                        n_space = e_space | 2'd1;
                                    end
                                end else if (i_ch == mae_pkg::CH_BSL) begin
                                    n_mode = M_COM_ESC;
                                end else if (i_ch == mae_pkg::CH_LPAR) begin
                                    if (e_depth < mae_pkg::NEST_W'(mae_pkg::MAX_NEST)) begin
                                        n_depth = e_depth + 1'b1;
                                    end else begin
                                        o_cmd.set_ovf = 1'b1;
                                    end
                                end
                            end
                            M_COM_ESC: begin
                                o_cmd.take = 1'b1;
                                n_mode     = M_COMMENT;
                            end
                            M_LITERAL: begin
                                o_cmd.take = 1'b1;
                                o_cmd.put  = 1'b1;
                                if (i_ch == (e_lbr ? mae_pkg::CH_RBRK : mae_pkg::CH_QUOTE)) begin
                                    n_mode = M_NORMAL;
                                end else if (i_ch == mae_pkg::CH_BSL) begin
                                    n_mode = M_LIT_ESC;
                                end
                            end
                            M_LIT_ESC: begin
                                o_cmd.take = 1'b1;
                                o_cmd.put  = 1'b1;
                                n_mode     = M_LITERAL;
                            end
                            M_ESCAPE: begin
                                if (new_word) begin
                                    do_emit = 1'b1;
                                    rsn     = mae_pkg::RSN_WORD;
                                end else begin
                                    n_space    = 2'd2;
                                    o_cmd.put  = 1'b1;
                                    o_cmd.take = 1'b1;
                                    n_mode     = M_NORMAL;
                                end
                            end
                            default: begin
                                case (i_ch)
                                    mae_pkg::CH_LT: begin
                                        if (e_angle == 2'd0) begin
                                            do_emit = 1'b1;
                                            rsn     = mae_pkg::RSN_NAME;
                                        end else begin
                                            o_cmd.clr_len = 1'b1;
                                            n_space       = 2'd0;
                                            o_cmd.take    = 1'b1;
                                        end
                                    end
                                    mae_pkg::CH_LPAR: begin
                                        o_cmd.take = 1'b1;
                                        n_depth    = mae_pkg::NEST_W'(1);
                                        n_mode     = M_COMMENT;
                                    end
                                    mae_pkg::CH_SP, mae_pkg::CH_TAB, mae_pkg::CH_LF: begin
                                        n_space    = e_space | 2'd1;
                                        o_cmd.take = 1'b1;
                                    end
                                    mae_pkg::CH_COMMA, mae_pkg::CH_SEMI: begin
                                        if (e_angle == 2'd0) begin
                                            do_emit = 1'b1;
                                            rsn     = mae_pkg::RSN_SEP;
                                        end else begin
                                            n_angle    = 2'd2;
                                            n_space    = 2'd0;
                                            o_cmd.put  = 1'b1;
                                            o_cmd.take = 1'b1;
                                        end
                                    end
                                    mae_pkg::CH_BSL: begin
                                        o_cmd.put  = 1'b1;
                                        o_cmd.take = 1'b1;
                                        n_mode     = M_ESCAPE;
                                    end
                                    mae_pkg::CH_GT: begin
                                        do_emit = 1'b1;
                                        wrp     = (e_angle == 2'd2);
                                    end
                                    mae_pkg::CH_AT, mae_pkg::CH_COLON, mae_pkg::CH_DOT: begin
                                        n_space    = 2'd0;
                                        o_cmd.put  = 1'b1;
                                        o_cmd.take = 1'b1;
                                    end
                                    mae_pkg::CH_LBRK, mae_pkg::CH_QUOTE: begin
                                        n_space    = 2'd2;
                                        n_lbr      = (i_ch == mae_pkg::CH_LBRK);
                                        o_cmd.put  = 1'b1;
                                        o_cmd.take = 1'b1;
                                        n_mode     = M_LITERAL;
                                    end
                                    default: begin
                                        if (new_word) begin
                                            do_emit = 1'b1;
                                            rsn     = mae_pkg::RSN_WORD;
                                        end else begin
                                            n_space    = 2'd2;
                                            o_cmd.put  = 1'b1;
                                            o_cmd.take = 1'b1;
                                        end
                                    end
                                endcase
                            end
                        endcase
                    end
                    if (do_emit) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.reason = rsn;
                        o_cmd.wrap   = wrp;
                        n_mode       = M_IDLE;
                        n_depth      = '0;
                        n_state      = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (i_stat.word_done) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (i_out_ready) begin
                    if (i_stat.last) begin
                        n_state = ST_SCAN;
                    end else begin
                        o_cmd.next_word = 1'b1;
                        n_state         = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_SCAN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SCAN;
            r_mode  <= M_IDLE;
            r_angle <= 2'd0;
            r_space <= 2'd0;
            r_lbr   <= 1'b0;
            r_depth <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_angle <= n_angle;
            r_space <= n_space;
            r_lbr   <= n_lbr;
            r_depth <= n_depth;
        end
    end

endmodule

/* hw/rtl/mail_address_extractor.sv */
// Top level of the mail address extractor: ties the scan controller to the datapath.
// Depends on mae_pkg, mae_if, mae_ctrl and mae_dpath.

// Header bytes are taken one per cycle while an address is being scanned; a byte
// with first set starts a new scan, and bytes with first clear outside a scan are
// taken and dropped. The byte that ends the scan (NUL, '>', separator, new word or
// display name) is not forwarded; it starts the emit phase, during which no input
// is taken. The collected address sits in a single-port byte memory and is read
// back one byte per cycle while an output word is being assembled; between words
// the readback waits until the output word is accepted.
// Every result word carries the stop reason, consumed count and overflow flag.
module mail_address_extractor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mae_byte_if.sink      i_byte,
    mae_word_if.source    o_addr
);

    mae_pkg::t_cmd  cmd;
    mae_pkg::t_stat stat;

    mae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_byte.valid),
        .i_ch        (i_byte.ch),
        .i_first     (i_byte.first),
        .o_in_ready  (i_byte.ready),
        .o_out_valid (o_addr.valid),
        .i_out_ready (o_addr.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mae_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ch          (i_byte.ch),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_data        (o_addr.data),
        .o_byte_count  (o_addr.byte_count),
        .o_stop_reason (o_addr.stop_reason),
        .o_consumed    (o_addr.consumed),
        .o_overflow    (o_addr.overflow)
    );

    assign o_addr.last = stat.last;

endmodule
